// ----- rtl/assert_macros.svh -----
// Assertion helpers for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/rks_pkg.sv -----
package rks_pkg;

	// Capacity of the record store
	localparam int MAX_RECORDS = 64;
	localparam int ADDR_W      = $clog2(MAX_RECORDS);
	localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

	// Fixed field widths
	localparam int KEY_W       = 16;
	localparam int POS_W       = 6;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 24;

	// One stored record
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [KEY_W-1:0] key;
	} rec_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_FETCH,
		ST_EMIT
	} state_t;

endpackage

// ----- rtl/record_key_sorter.sv -----
// Record key sorter. Records arrive one per transaction on the slave side, each with a
// 16-bit key; tlast marks the last record of a batch. Records are kept in key order as
// they arrive: a new record is compared against the stored records from the top down by
// one shared comparator, and every larger one moves up one slot (equal keys keep arrival
// order). While a record is stored, each stored key larger than it moves up in turn
// before the new one is written, paced by the single read and single write port of the
// record memory; s_tready is low meanwhile. Records beyond MAX_RECORDS are dropped and
// flagged on m_tuser. After the last record is stored, a fetch state follows, then the
// batch is streamed out in ascending key order at one transaction per cycle while
// m_tready is high, each with its arrival position, tlast on the final one. No input is
// taken until the whole batch has been sent. No clearing pass is needed after reset.
module record_key_sorter
	import rks_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] record_key
	input  logic                   s_tlast,   // final_record
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [15:0] sorted_key, [21:16] arrival_position
	output logic                   m_tuser,   // overflow_seen
	output logic                   m_tlast    // end_of_batch
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic              overflow_q;
	logic              last_q;
	logic [ADDR_W-1:0] slot_q;
	logic [ADDR_W-1:0] idx_q;
	logic [KEY_W-1:0]  key_q;
	logic [POS_W-1:0]  pos_q;

	rec_t              mem_q [MAX_RECORDS];
	rec_t              rd_data_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	rec_t              wr_data;
	logic              wr_en;

	logic in_xfer, out_xfer, full, move_up, batch_done;

	assign in_xfer    = s_tvalid && s_tready;
	assign out_xfer   = m_tvalid && m_tready;
	assign full       = (count_q == CNT_W'(MAX_RECORDS));
	// shared comparator: stored record above the new one moves up
	assign move_up    = (slot_q != '0) && (rd_data_q.key > key_q);
	assign batch_done = (CNT_W'(idx_q) + CNT_W'(1) == count_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (!full) begin
						state_d = ST_SHIFT;
					end else if (s_tlast) begin
						state_d = ST_FETCH;
					end
				end
			end
			ST_SHIFT: begin
				if (!move_up) begin
					state_d = last_q ? ST_FETCH : ST_IDLE;
				end
			end
			ST_FETCH: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_xfer && batch_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port control and handshake outputs
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		m_tvalid = (state_q == ST_EMIT);
		wr_en    = 1'b0;
		wr_addr  = slot_q;
		wr_data  = rd_data_q;
		rd_addr  = idx_q;
		unique case (state_q)
			ST_IDLE:  rd_addr = count_q[ADDR_W-1:0] - ADDR_W'(1);
			ST_SHIFT: begin
				wr_en = 1'b1;
				if (move_up) begin
					rd_addr = slot_q - ADDR_W'(2);
				end else begin
					wr_data.key = key_q;
					wr_data.pos = pos_q;
				end
			end
			ST_FETCH: rd_addr = idx_q;
			ST_EMIT:  rd_addr = out_xfer ? idx_q + ADDR_W'(1) : idx_q;
			default:  rd_addr = idx_q;
		endcase
	end

	assign m_tdata = {{(OUT_TDATA_W - KEY_W - POS_W){1'b0}}, rd_data_q.pos, rd_data_q.key};
	assign m_tuser = overflow_q;
	assign m_tlast = batch_done;

	// Record memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// Sequencer and batch control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			overflow_q <= 1'b0;
			last_q     <= 1'b0;
			idx_q      <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						last_q <= s_tlast;
						idx_q  <= '0;
						if (full) begin
							overflow_q <= 1'b1;
						end
					end
				end
				ST_SHIFT: begin
					if (!move_up) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				ST_FETCH: idx_q <= idx_q;
				ST_EMIT: begin
					if (out_xfer) begin
						idx_q <= idx_q + ADDR_W'(1);
						if (batch_done) begin
							count_q    <= '0;
							overflow_q <= 1'b0;
						end
					end
				end
				default: idx_q <= '0;
			endcase
		end
	end

	// Insertion slot and the record being placed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			key_q  <= s_tdata[KEY_W-1:0];
			pos_q  <= POS_W'(count_q);
			slot_q <= count_q[ADDR_W-1:0];
		end else if (state_q == ST_SHIFT && move_up) begin
			slot_q <= slot_q - ADDR_W'(1);
		end
	end

endmodule

// ----- rtl/rks_checker.sv -----
`include "assert_macros.svh"

// Port-level checks for the record key sorter
module rks_checker
	import rks_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   s_tlast,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser,
	input logic                   m_tlast
);

	// full result word as seen on the master side
	logic [OUT_TDATA_W+1:0] out_word;

	assign out_word = {m_tlast, m_tuser, m_tdata};

	// input is never taken while results are being offered
	`ASSERT_SAME(a_no_overlap, clk, arst_n, 1'b1, !(s_tready && m_tvalid))

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(out_word))

	// a non-final record never produces a result right away
	`ASSERT_NEXT(a_no_early_out, clk, arst_n, s_tvalid && s_tready && !s_tlast, !m_tvalid)

	// after the final result the block is ready for a new batch
	`ASSERT_NEXT(a_batch_end, clk, arst_n, m_tvalid && m_tready && m_tlast, s_tready && !m_tvalid)

endmodule

bind record_key_sorter rks_checker u_rks_checker (.*);
